### rtl/core/apdu_pkg.sv
package apdu_pkg;

  localparam int JOB_BYTES       = 7;
  localparam int JOB_COUNT_W     = 3;
  localparam int JOB_QUEUE_DEPTH = 4;

  localparam logic [16:0] NE_MAX       = 17'd65536;
  localparam logic [16:0] NE_SHORT_MAX = 17'd256;
  localparam logic [15:0] NC_SHORT_MAX = 16'd255;
  localparam logic [7:0]  ZERO_BYTE    = 8'h00;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_DATA   = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  class_byte;
    logic [7:0]  instruction_byte;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [15:0] data_length;
    logic [16:0] expected_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       apdu_end;
  } out_item_t;

  // A run of output bytes produced by one accepted item; only the final
  // byte of a run can close an APDU.
  typedef struct packed {
    logic [JOB_COUNT_W-1:0]      count;
    logic                        end_flag;
    logic [JOB_BYTES-1:0][7:0]   bytes;
  } job_t;

endpackage

### rtl/core/apdu_front.sv
module apdu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  apdu_pkg::in_item_t item,
  output logic              job_push,
  output apdu_pkg::job_t    job
);
  import apdu_pkg::*;

  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [16:0] pending_ne, pending_ne_next;
  logic        extended_form, extended_form_next;

  logic        accept;
  logic [16:0] ne_sat;
  logic        ext;
  logic        produce;

  assign accept = push && !full;
  assign ne_sat = (item.expected_length > NE_MAX) ? NE_MAX : item.expected_length;
  assign ext    = (item.data_length > NC_SHORT_MAX) || (ne_sat > NE_SHORT_MAX);

  always_comb begin
    job                  = '0;
    produce              = 1'b1;
    bytes_remaining_next = bytes_remaining;
    pending_ne_next      = pending_ne;
    extended_form_next   = extended_form;
    if (item.func == FUNC_HEADER) begin
      job.bytes[0] = item.class_byte;
      job.bytes[1] = item.instruction_byte;
      job.bytes[2] = item.param_one;
      job.bytes[3] = item.param_two;
      if (item.data_length == 16'd0) begin
        bytes_remaining_next = 16'd0;
        pending_ne_next      = 17'd0;
        extended_form_next   = 1'b0;
        job.end_flag         = 1'b1;
        if (ne_sat == 17'd0) begin
          job.count = JOB_COUNT_W'(4);
        end else if (!ext) begin
          job.bytes[4] = ne_sat[7:0];
          job.count    = JOB_COUNT_W'(5);
        end else begin
          // no Lc field, so extended Le carries a leading zero
          job.bytes[4] = ZERO_BYTE;
          job.bytes[5] = ne_sat[15:8];
          job.bytes[6] = ne_sat[7:0];
          job.count    = JOB_COUNT_W'(7);
        end
      end else begin
        bytes_remaining_next = item.data_length;
        pending_ne_next      = ne_sat;
        extended_form_next   = ext;
        if (ext) begin
          job.bytes[4] = ZERO_BYTE;
          job.bytes[5] = item.data_length[15:8];
          job.bytes[6] = item.data_length[7:0];
          job.count    = JOB_COUNT_W'(7);
        end else begin
          job.bytes[4] = item.data_length[7:0];
          job.count    = JOB_COUNT_W'(5);
        end
      end
    end else if (bytes_remaining == 16'd0) begin
      // drop stray data byte
      produce = 1'b0;
    end else begin
      bytes_remaining_next = bytes_remaining - 16'd1;
      job.bytes[0]         = item.data_byte;
      job.count            = JOB_COUNT_W'(1);
      if (bytes_remaining == 16'd1) begin
        pending_ne_next    = 17'd0;
        extended_form_next = 1'b0;
        job.end_flag       = 1'b1;
        if (pending_ne != 17'd0) begin
          if (!extended_form) begin
            job.bytes[1] = pending_ne[7:0];
            job.count    = JOB_COUNT_W'(2);
          end else begin
            job.bytes[1] = pending_ne[15:8];
            job.bytes[2] = pending_ne[7:0];
            job.count    = JOB_COUNT_W'(3);
          end
        end
      end
    end
  end

  assign job_push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      pending_ne      <= '0;
      extended_form   <= 1'b0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      pending_ne      <= pending_ne_next;
      extended_form   <= extended_form_next;
    end
  end

endmodule

### rtl/core/apdu_jobq.sv
module apdu_jobq #(
  parameter int DEPTH = apdu_pkg::JOB_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  apdu_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output apdu_pkg::job_t rd_job,
  output logic           rd_valid
);
  import apdu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr, do_rd;

  assign full     = (fill == CW'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

### rtl/core/apdu_back.sv
module apdu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  apdu_pkg::job_t      job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output apdu_pkg::out_item_t result
);
  import apdu_pkg::*;

  logic [JOB_COUNT_W-1:0] idx;
  logic                   out_valid;
  out_item_t              out_reg;
  logic                   advance;
  logic                   last_of_job;

  assign advance     = !out_valid || pop;
  assign last_of_job = (idx == job.count - JOB_COUNT_W'(1));
  assign job_pop     = advance && job_valid && last_of_job;
  assign empty       = !out_valid;
  assign result      = out_reg;

  always_ff @(posedge clk) begin
    if (advance && job_valid) begin
      out_reg.out_byte <= job.bytes[idx];
      out_reg.apdu_end <= job.end_flag && last_of_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= job_valid;
      if (job_valid) begin
        idx <= last_of_job ? '0 : idx + JOB_COUNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/apdu_command_encoder.sv
// Command APDU serializer, short and extended form, with or without data and Le.
// Input queue side: drive item and raise push; the item is taken on an edge
// where full is low. A header item (func = 0) starts a command, data items
// (func = 1) carry one command byte each.
// Result queue side: while empty is low, result holds the next encoded byte
// and its apdu_end flag; raise pop to take it.
// Flow: an accepted item's bytes are written into the job queue, then moved
// through the output register to the result ports. A header expands into
// 4 to 7 bytes, the closing data byte into 1 to 3, and the serializer emits
// one byte per cycle while pop keeps the output register free, so data bytes
// stream at one per cycle. The job queue between classifier and serializer
// (QUEUE_DEPTH entries) absorbs header bursts; full rises only when it fills.
// When pop is held low the output register holds its byte, the serializer
// stops, and the queue fills until full asserts; nothing is lost.
// Reset clears the command state and the job queue and marks the output
// register empty.
module apdu_command_encoder #(
  parameter int QUEUE_DEPTH = apdu_pkg::JOB_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  apdu_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output apdu_pkg::out_item_t result
);
  import apdu_pkg::*;

  logic job_push, job_pop, job_valid;
  job_t wr_job, rd_job;

  apdu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (job_push),
    .job      (wr_job)
  );

  apdu_jobq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (wr_job),
    .full     (full),
    .rd_en    (job_pop),
    .rd_job   (rd_job),
    .rd_valid (job_valid)
  );

  apdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (rd_job),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### verif/apdu_encoder_scoreboard.sv
package apdu_encoder_scoreboard_pkg;
  import apdu_pkg::*;

  class apdu_byte_scoreboard;
    out_item_t   pending_bytes[$];
    logic [15:0] data_left;
    logic [16:0] held_ne;
    logic        held_ext;
    int          errors;
    int          bytes_checked;
    int          apdus_closed;
    int          commands_seen;
    int          stray_beats;

    function new();
      data_left     = '0;
      held_ne       = '0;
      held_ext      = 1'b0;
      errors        = 0;
      bytes_checked = 0;
      apdus_closed  = 0;
      commands_seen = 0;
      stray_beats   = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void add_byte(logic [7:0] b, logic last);
      out_item_t o;
      o.out_byte = b;
      o.apdu_end = last;
      pending_bytes = {pending_bytes, o};
    endfunction

    // Le field; the leading zero only appears when there is no Lc field.
    function void add_le(logic [16:0] ne, logic ext, logic lead_zero);
      if (!ext) begin
        add_byte(ne[7:0], 1'b1);
      end else begin
        if (lead_zero) add_byte(ZERO_BYTE, 1'b0);
        add_byte(ne[15:8], 1'b0);
        add_byte(ne[7:0], 1'b1);
      end
    endfunction

    // Work out the encoded bytes for one accepted beat; returns their number.
    function int encode_item(in_item_t it);
      logic [15:0] nc;
      logic [16:0] ne;
      logic        ext;
      int          before_cnt;
      before_cnt = pending_bytes.size();
      if (it.func == FUNC_HEADER) begin
        commands_seen++;
        nc  = it.data_length;
        ne  = (it.expected_length > NE_MAX) ? NE_MAX : it.expected_length;
        ext = (nc > NC_SHORT_MAX) || (ne > NE_SHORT_MAX);
        add_byte(it.class_byte, 1'b0);
        add_byte(it.instruction_byte, 1'b0);
        add_byte(it.param_one, 1'b0);
        if (nc == '0) begin
          data_left = '0;
          held_ne   = '0;
          held_ext  = 1'b0;
          if (ne == '0) begin
            add_byte(it.param_two, 1'b1);
          end else begin
            add_byte(it.param_two, 1'b0);
            add_le(ne, ext, 1'b1);
          end
        end else begin
          add_byte(it.param_two, 1'b0);
          if (ext) begin
            add_byte(ZERO_BYTE, 1'b0);
            add_byte(nc[15:8], 1'b0);
          end
          add_byte(nc[7:0], 1'b0);
          data_left = nc;
          held_ne   = ne;
          held_ext  = ext;
        end
      end else if (data_left == '0) begin
        stray_beats++;
      end else begin
        data_left = data_left - 16'd1;
        if (data_left != '0) begin
          add_byte(it.data_byte, 1'b0);
        end else begin
          if (held_ne == '0) begin
            add_byte(it.data_byte, 1'b1);
          end else begin
            add_byte(it.data_byte, 1'b0);
            add_le(held_ne, held_ext, 1'b0);
          end
          held_ne  = '0;
          held_ext = 1'b0;
        end
      end
      return pending_bytes.size() - before_cnt;
    endfunction

    task check_byte(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h end=%0b", got.out_byte, got.apdu_end));
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (got.apdu_end === 1'b1) apdus_closed++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("byte %0d: out_byte %02h, want %02h",
                         bytes_checked, got.out_byte, want.out_byte));
      if (got.apdu_end !== want.apdu_end)
        report($sformatf("byte %0d: apdu_end %0b, want %0b",
                         bytes_checked, got.apdu_end, want.apdu_end));
    endtask

    task check_leftovers();
      if (pending_bytes.size() != 0)
        report($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
    endtask
  endclass

endpackage

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apdu_pkg::*;
  import apdu_encoder_scoreboard_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;

  apdu_byte_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int productive_beats;

  apdu_command_encoder uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** apdu_command_encoder: FAILED **");
    $finish;
  end

  // Result side: check every popped beat, stall at the phase's rate.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && pop && !empty) sb.check_byte(result);
      pop <= (rst === 1'b0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.func             = 1'($urandom_range(1));
    it.class_byte       = 8'($urandom_range(255));
    it.instruction_byte = 8'($urandom_range(255));
    it.param_one        = 8'($urandom_range(255));
    it.param_two        = 8'($urandom_range(255));
    it.data_length      = 16'($urandom_range(65535));
    it.expected_length  = 17'($urandom_range(131071));
    it.data_byte        = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic drive_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    if (sb.encode_item(it) > 0) productive_beats++;
  endtask

  task automatic send_header(logic [7:0] cla, logic [7:0] ins, logic [7:0] p1,
                             logic [7:0] p2, logic [15:0] nc, logic [16:0] ne);
    in_item_t it;
    it                  = noise_item();
    it.func             = FUNC_HEADER;
    it.class_byte       = cla;
    it.instruction_byte = ins;
    it.param_one        = p1;
    it.param_two        = p2;
    it.data_length      = nc;
    it.expected_length  = ne;
    drive_item(it);
  endtask

  task automatic send_data(logic [7:0] b);
    in_item_t it;
    it           = noise_item();
    it.func      = FUNC_DATA;
    it.data_byte = b;
    drive_item(it);
  endtask

  // Hold the sender until every expected byte has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending_bytes.size() != 0);
  endtask

  task automatic run_random(int target);
    int          start_cnt;
    int          roll;
    int          n_data;
    logic [15:0] nc;
    logic [16:0] ne;
    start_cnt = productive_beats;
    while (productive_beats - start_cnt < target) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        // stray beat with no command open
        send_data(8'($urandom_range(255)));
      end else if (roll < 11) begin
        wait_drained();
      end else begin
        roll = $urandom_range(99);
        if (roll < 55)      nc = 16'($urandom_range(0, 6));
        else if (roll < 85) nc = 16'($urandom_range(7, 24));
        else if (roll < 88) nc = 16'($urandom_range(256, 264));
        else                nc = 16'($urandom_range(65535));
        roll = $urandom_range(99);
        if (roll < 30)      ne = '0;
        else if (roll < 55) ne = 17'($urandom_range(1, 255));
        else if (roll < 65) ne = NE_SHORT_MAX;
        else if (roll < 80) ne = 17'($urandom_range(257, 65535));
        else if (roll < 90) ne = NE_MAX;
        else                ne = 17'($urandom_range(65537, 131071));
        send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)), nc, ne);
        // Abandon extended-length or unlucky commands part way; a new header follows.
        if (nc == '0) n_data = 0;
        else if (nc > NC_SHORT_MAX || $urandom_range(99) < 6)
          n_data = $urandom_range(0, (nc < 16'd6) ? int'(nc) - 1 : 5);
        else n_data = int'(nc);
        repeat (n_data) send_data(8'($urandom_range(255)));
        if (n_data != int'(nc)) begin
          send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)), 16'd0, '0);
        end
      end
    end
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    sb               = new();
    productive_beats = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    phase_idle       = '{0, 64, 0, 10};
    phase_stall      = '{0, 0, 64, 10};
    rst  = 1'b1;
    push = 1'b0;
    item = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header only, both byte extremes
    send_header(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 17'd0);
    send_header(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 17'd0);
    send_data(8'hA5);
    // Le without data, short and extended, incl. 256, 65536 and saturated Ne
    send_header(8'h00, 8'hB0, 8'h00, 8'h00, 16'd0, 17'd256);
    send_header(8'h80, 8'hCA, 8'h9F, 8'h7F, 16'd0, 17'd1);
    send_header(8'h00, 8'hB0, 8'h01, 8'h02, 16'd0, 17'd257);
    send_header(8'h00, 8'hB0, 8'h03, 8'h04, 16'd0, 17'd65535);
    send_header(8'h00, 8'hB0, 8'h05, 8'h06, 16'd0, 17'd65536);
    send_header(8'h0C, 8'hB0, 8'h07, 8'h08, 16'd0, 17'h1FFFF);
    // short data without Le, then short data with Le
    send_header(8'h00, 8'hA4, 8'h04, 8'h00, 16'd1, 17'd0);
    send_data(8'hFF);
    send_header(8'h00, 8'h88, 8'h00, 8'h00, 16'd2, 17'd256);
    send_data(8'h00);
    send_data(8'h5A);
    // data with Le, extended through Ne alone
    send_header(8'h00, 8'h2A, 8'h9E, 8'h9A, 16'd1, 17'd65536);
    send_data(8'h3C);
    send_header(8'h00, 8'h2A, 8'h80, 8'h86, 16'd1, 17'd65535);
    send_data(8'hC3);
    // abandon an extended command with the largest Nc, then a short one
    send_header(8'h10, 8'hD6, 8'h00, 8'h00, 16'd65535, 17'd300);
    send_data(8'h11);
    send_data(8'h22);
    send_header(8'h00, 8'hDA, 8'h01, 8'h01, 16'd255, 17'd0);
    send_data(8'h33);
    send_header(8'h00, 8'h20, 8'h00, 8'h81, 16'd0, 17'd0);
    send_data(8'h44);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      run_random(20);
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    sb.check_leftovers();

    $display("Covered %0d commands, %0d encoded bytes checked, %0d APDUs closed,",
             sb.commands_seen, sb.bytes_checked, sb.apdus_closed);
    $display("%0d stray data beats dropped, over four sender/receiver pacing phases.",
             sb.stray_beats);
    if (sb.errors == 0) begin
      $display("** apdu_command_encoder: PASSED **");
    end else begin
      $display("** apdu_command_encoder: FAILED **");
    end
    $finish;
  end

endmodule
